FILE: hdl/sca_pkg.sv
// Shared types and constants for the slice coverage reassembly block.
// No dependencies; every other file in hdl/ imports this package.
package sca_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int ELEM_COUNT_DEF = 96;
    localparam int ELEM_LIMIT     = 96;
    localparam int KEY_W          = 32;
    localparam int BYTE_W         = 8;
    localparam int COUNT_W        = 7;
    localparam int SLOT_OUT_W     = 3;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int S_TDATA_W      = 56;
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 24;
    localparam int M_TUSER_W      = 3;

    // Register index as seen on paddr[2]
    localparam logic REG_BLOCK_ENABLE = 1'b0;

    typedef enum logic [1:0] {
        ACT_SLICE  = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_FORGET = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_PARTIAL    = 3'd0,
        ST_COMPLETE   = 3'd1,
        ST_BAD_SLICE  = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_CLEARED    = 3'd4,
        ST_NOT_FOUND  = 3'd5,
        ST_DISABLED   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        KIND_UNUSED   = 3'd0,
        KIND_DISABLED = 3'd1,
        KIND_NO_KEY   = 3'd2,
        KIND_SLICE    = 3'd3,
        KIND_CLEAR    = 3'd4,
        KIND_FORGET   = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [KEY_W-1:0]      key;
        logic [COUNT_W-1:0]    total;
        logic                  bad;
        logic [COUNT_W-1:0]    clipped;
        logic [ELEM_LIMIT-1:0] seg_mask;
        logic [ELEM_LIMIT-1:0] tot_mask;
    } t_job;

    typedef struct packed {
        t_status               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [COUNT_W-1:0]    usable;
        logic                  sweep;
        logic                  discarded;
        logic [COUNT_W-1:0]    clipped;
    } t_result;

endpackage

FILE: hdl/sca_front.sv
// Front end: decode an incoming word, clip the slice and build its masks.
// Depends on sca_pkg.
module sca_front
    import sca_pkg::*;
#(
    parameter int MAX_ELEMENTS = ELEM_COUNT_DEF
) (
    input  t_action            i_action,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [BYTE_W-1:0]  i_claimed,
    input  logic [BYTE_W-1:0]  i_first,
    input  logic [BYTE_W-1:0]  i_count,
    input  logic               i_enable,
    output t_job               o_job
);

    localparam logic [BYTE_W-1:0]  MAX_B = BYTE_W'(MAX_ELEMENTS);
    localparam logic [COUNT_W-1:0] MAX_C = COUNT_W'(MAX_ELEMENTS);

    logic [COUNT_W-1:0] w_total;
    logic [BYTE_W-1:0]  w_total_b;
    logic [BYTE_W:0]    w_sum;
    logic               w_bad;
    logic [COUNT_W-1:0] w_clipped;
    logic [BYTE_W-1:0]  w_end;

    assign w_total   = (i_claimed < MAX_B) ? i_claimed[COUNT_W-1:0] : MAX_C;
    assign w_total_b = {1'b0, w_total};
    assign w_bad     = (i_first >= w_total_b) || (i_count == '0);
    assign w_sum     = {1'b0, i_first} + {1'b0, i_count};

    always_comb begin
        if (w_bad) begin
            w_clipped = '0;
        end else if (w_sum > {1'b0, w_total_b}) begin
            w_clipped = w_total - i_first[COUNT_W-1:0];
        end else begin
            w_clipped = i_count[COUNT_W-1:0];
        end
    end

    assign w_end = i_first + {1'b0, w_clipped};

    always_comb begin
        o_job         = '0;
        o_job.key     = i_key;
        o_job.total   = w_total;
        o_job.bad     = w_bad;
        o_job.clipped = w_clipped;
        for (int b = 0; b < ELEM_LIMIT; b++) begin
            o_job.seg_mask[b] = !w_bad && (BYTE_W'(b) >= i_first) && (BYTE_W'(b) < w_end);
            o_job.tot_mask[b] = BYTE_W'(b) < w_total_b;
        end
        // Unused action wins over everything, forget ignores the enable
        priority if (i_action == ACT_UNUSED) begin
            o_job.kind = KIND_UNUSED;
        end else if (i_action != ACT_FORGET && !i_enable) begin
            o_job.kind = KIND_DISABLED;
        end else if (i_key == '0) begin
            o_job.kind = KIND_NO_KEY;
        end else if (i_action == ACT_SLICE) begin
            o_job.kind = KIND_SLICE;
        end else if (i_action == ACT_CLEAR) begin
            o_job.kind = KIND_CLEAR;
        end else begin
            o_job.kind = KIND_FORGET;
        end
    end

endmodule

FILE: hdl/sca_queue.sv
// Short job queue between the front end and the slot table.
// Depends on sca_pkg.
module sca_queue
    import sca_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_ready,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

    t_job             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == FULL) |-> !i_push)
        else $error("push into full queue");

endmodule

FILE: hdl/sca_back.sv
// Back end: slot table lookup, coverage update and the result register.
// Depends on sca_pkg.
module sca_back
    import sca_pkg::*;
#(
    parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
    parameter int MAX_ELEMENTS = ELEM_COUNT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_pop,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [KEY_W-1:0]        r_handle [SLOT_COUNT];
    logic [MAX_ELEMENTS-1:0] r_map    [SLOT_COUNT];
    logic [COUNT_W-1:0]      r_total  [SLOT_COUNT];
    logic [COUNT_W-1:0]      r_usable [SLOT_COUNT];

    logic                    r_valid, n_valid;
    t_result                 r_result, n_result;

    logic [SLOT_COUNT-1:0]   w_hit;
    logic                    w_hit_any, w_free_any;
    logic [SLOT_W-1:0]       w_hit_idx, w_free_idx, w_sel;
    logic [SLOT_W+SLOT_OUT_W-1:0] w_sel_ext;
    logic                    w_claim;
    logic [MAX_ELEMENTS-1:0] w_old_map, w_base_map, w_new_map;
    logic [MAX_ELEMENTS-1:0] w_seg, w_tot;
    logic [COUNT_W-1:0]      w_old_total, w_old_use, w_base_use, w_new_use;
    logic                    w_changed, w_whole;
    logic                    w_do_slice, w_do_clear, w_do_forget;

    // Lowest matching slot and lowest free slot
    always_comb begin
        w_hit      = '0;
        w_hit_any  = 1'b0;
        w_hit_idx  = '0;
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            w_hit[i] = (r_handle[i] == i_job.key);
            if (w_hit[i]) begin
                w_hit_any = 1'b1;
                w_hit_idx = SLOT_W'(i);
            end
            if (r_handle[i] == '0) begin
                w_free_any = 1'b1;
                w_free_idx = SLOT_W'(i);
            end
        end
    end

    assign w_sel     = w_hit_any ? w_hit_idx : w_free_idx;
    assign w_sel_ext = {{SLOT_OUT_W{1'b0}}, w_sel};
    assign w_claim   = !w_hit_any && w_free_any;

    // A freshly claimed slot starts empty
    assign w_old_map   = w_claim ? '0 : r_map[w_sel];
    assign w_old_total = w_claim ? '0 : r_total[w_sel];
    assign w_old_use   = w_claim ? '0 : r_usable[w_sel];

    assign w_seg      = i_job.seg_mask[MAX_ELEMENTS-1:0];
    assign w_tot      = i_job.tot_mask[MAX_ELEMENTS-1:0];
    assign w_changed  = (w_old_total != i_job.total);
    assign w_base_map = w_changed ? '0 : w_old_map;
    assign w_base_use = w_changed ? '0 : w_old_use;
    assign w_new_map  = w_base_map | w_seg;
    assign w_whole    = !i_job.bad && (&(w_new_map | ~w_tot));
    assign w_new_use  = w_whole ? i_job.total : w_base_use;

    always_comb begin
        n_result        = '0;
        n_result.status = ST_BAD_SLICE;
        w_do_slice      = 1'b0;
        w_do_clear      = 1'b0;
        w_do_forget     = 1'b0;
        unique case (i_job.kind)
            KIND_UNUSED: begin
                n_result.status = ST_BAD_SLICE;
            end
            KIND_DISABLED: begin
                n_result.status = ST_DISABLED;
            end
            KIND_NO_KEY: begin
                n_result.status = ST_NOT_FOUND;
            end
            KIND_FORGET: begin
                if (w_hit_any) begin
                    n_result.status = ST_CLEARED;
                    n_result.slot   = w_sel_ext[SLOT_OUT_W-1:0];
                    w_do_forget     = 1'b1;
                end else begin
                    n_result.status = ST_NOT_FOUND;
                end
            end
            KIND_CLEAR: begin
                if (w_hit_any) begin
                    n_result.status    = ST_CLEARED;
                    n_result.slot      = w_sel_ext[SLOT_OUT_W-1:0];
                    n_result.discarded = (w_old_use != '0);
                    w_do_clear         = 1'b1;
                end else begin
                    n_result.status = ST_NOT_FOUND;
                end
            end
            KIND_SLICE: begin
                if (!w_hit_any && !w_free_any) begin
                    n_result.status = ST_TABLE_FULL;
                end else begin
                    w_do_slice      = 1'b1;
                    n_result.slot   = w_sel_ext[SLOT_OUT_W-1:0];
                    n_result.usable = w_new_use;
                    if (i_job.bad) begin
                        n_result.status = ST_BAD_SLICE;
                    end else begin
                        n_result.status  = w_whole ? ST_COMPLETE : ST_PARTIAL;
                        n_result.sweep   = w_whole && (w_base_use == '0);
                        n_result.clipped = i_job.clipped;
                    end
                end
            end
            default: begin
                n_result.status = ST_BAD_SLICE;
            end
        endcase
    end

    // Advance when the result register is empty or being drained
    assign o_job_pop = i_job_valid && (!r_valid || i_ready);

    always_comb begin
        n_valid = r_valid;
        if (o_job_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_handle[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            if (o_job_pop && w_do_forget) begin
                r_handle[w_sel] <= '0;
            end else if (o_job_pop && w_do_slice) begin
                r_handle[w_sel] <= i_job.key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_result <= n_result;
            if (w_do_slice) begin
                r_map[w_sel]    <= w_new_map;
                r_total[w_sel]  <= i_job.total;
                r_usable[w_sel] <= w_new_use;
            end else if (w_do_clear) begin
                r_usable[w_sel] <= '0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_unique_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job_valid && (i_job.kind == KIND_SLICE || i_job.kind == KIND_CLEAR ||
                         i_job.kind == KIND_FORGET)) |-> $onehot0(w_hit))
        else $error("stream handle held by more than one slot");

    a_complete_usable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.status == ST_COMPLETE) |->
            (r_result.usable != '0 && r_result.clipped != '0))
        else $error("complete result without usable count");

    a_sweep_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.sweep) |-> (r_result.status == ST_COMPLETE))
        else $error("sweep flag on a result that is not complete");

endmodule

FILE: hdl/slice_coverage_reassembly.sv
// Slice coverage reassembly tracker: top level with the register port.
// An accepted word passes through the job queue and the result register to the master side.
// Throughput: one word per cycle while m_tready is high; the slot compare, coverage merge and
// full-coverage check are combinational, and a two-entry job queue absorbs output stalls.
// Reset (synchronous, active low): every slot free, queue and result register empty,
// block_enable set to 1. No clearing pass; the first word is taken right after reset.
module slice_coverage_reassembly
    import sca_pkg::*;
#(
    parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
    parameter int MAX_ELEMENTS = ELEM_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // stream_key[31:0], claimed_total[39:32], first_index[47:40], element_count[55:48]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [S_TUSER_W-1:0]  s_tuser,
    // Master side
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // slot_index[2:0], usable_count[9:3], sweep_completed[10],
    // complete_discarded[11], clipped_count[18:12], zero pad[23:19]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status[2:0]
    output logic [M_TUSER_W-1:0]  m_tuser,
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic    r_block_enable, n_block_enable;
    logic    w_cfg_write;
    t_job    w_front_job;
    t_job    w_queue_job;
    logic    w_queue_valid;
    logic    w_queue_pop;
    t_result w_result;

    // Register port: zero wait states, one register at word 0
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        n_block_enable = r_block_enable;
        if (w_cfg_write && paddr[2] == REG_BLOCK_ENABLE) begin
            n_block_enable = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_enable <= 1'b1;
        end else begin
            r_block_enable <= n_block_enable;
        end
    end

    assign prdata = (paddr[2] == REG_BLOCK_ENABLE) ? {{(CFG_DATA_W-1){1'b0}}, r_block_enable}
                                                   : '0;

    // Classify and clip each word as it arrives
    sca_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .i_action  (t_action'(s_tuser)),
        .i_key     (s_tdata[31:0]),
        .i_claimed (s_tdata[39:32]),
        .i_first   (s_tdata[47:40]),
        .i_count   (s_tdata[55:48]),
        .i_enable  (r_block_enable),
        .o_job     (w_front_job)
    );

    // Decouple acceptance from result drain
    sca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_tvalid && s_tready),
        .i_job   (w_front_job),
        .o_ready (s_tready),
        .o_valid (w_queue_valid),
        .o_job   (w_queue_job),
        .i_pop   (w_queue_pop)
    );

    // Slot table and result register
    sca_back #(
        .SLOT_COUNT   (SLOT_COUNT),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_queue_valid),
        .i_job       (w_queue_job),
        .o_job_pop   (w_queue_pop),
        .o_valid     (m_tvalid),
        .o_result    (w_result),
        .i_ready     (m_tready)
    );

    assign m_tuser = w_result.status;
    assign m_tdata = {5'b0, w_result.clipped, w_result.discarded, w_result.sweep,
                      w_result.usable, w_result.slot};

endmodule
